### src/sos_pkg.sv
// Shared types, sizes and codes for the set_of_stacks block.
package sos_pkg;

    localparam int MAX_CAPACITY = 16;
    localparam int MAX_STACKS   = 16;

    localparam int FILL_W = $clog2(MAX_CAPACITY + 1);
    localparam int SLOT_W = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int LIVE_W = $clog2(MAX_STACKS + 1);
    localparam int DEPTH  = MAX_STACKS * MAX_CAPACITY;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam int IDX_W  = 4;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_POP_AT = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    localparam logic REG_SUB_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] SUB_CAPACITY_RESET = CAP_W'(2);

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] push_value;
        logic [IDX_W-1:0]         stack_index;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] pop_value;
        logic [1:0]               status;
    } t_out_beat;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [1:0]        status;
    } t_plan;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

endpackage

### src/sos_ram.sv
// Generic single-port RAM with a registered read.
module sos_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/sos_dir.sv
// Sub-stack directory: fill counts, list order, slot allocation and the per-command plan.
module sos_dir (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  sos_pkg::t_in_beat           i_beat,
    input  logic [sos_pkg::CAP_W-1:0]   i_sub_capacity,
    output sos_pkg::t_plan              o_plan
);

    logic [sos_pkg::FILL_W-1:0] r_fill  [sos_pkg::MAX_STACKS];
    logic [sos_pkg::FILL_W-1:0] n_fill  [sos_pkg::MAX_STACKS];
    logic [sos_pkg::SLOT_W-1:0] r_order [sos_pkg::MAX_STACKS];
    logic [sos_pkg::SLOT_W-1:0] n_order [sos_pkg::MAX_STACKS];
    logic [sos_pkg::LIVE_W-1:0] r_live;
    logic [sos_pkg::LIVE_W-1:0] n_live;
    logic [sos_pkg::MAX_STACKS-1:0] r_in_use;
    logic [sos_pkg::MAX_STACKS-1:0] n_in_use;

    logic [sos_pkg::FILL_W-1:0] eff_cap;
    logic [sos_pkg::SLOT_W-1:0] free_slot;
    logic                       free_found;
    logic [sos_pkg::SLOT_W-1:0] last_pos;
    logic [sos_pkg::SLOT_W-1:0] pos;
    logic [sos_pkg::SLOT_W-1:0] slot;
    logic [sos_pkg::FILL_W-1:0] fill;
    logic                       need_new;
    sos_pkg::t_plan             plan;

    always_comb begin
        if (i_sub_capacity == '0) begin
            eff_cap = sos_pkg::FILL_W'(1);
        end else if (32'(i_sub_capacity) > 32'(sos_pkg::MAX_CAPACITY)) begin
            eff_cap = sos_pkg::FILL_W'(sos_pkg::MAX_CAPACITY);
        end else begin
            eff_cap = sos_pkg::FILL_W'(i_sub_capacity);
        end
    end

    always_comb begin
        free_slot  = '0;
        free_found = 1'b0;
        for (int i = sos_pkg::MAX_STACKS - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                free_slot  = sos_pkg::SLOT_W'(i);
                free_found = 1'b1;
            end
        end
    end

    assign last_pos = sos_pkg::SLOT_W'(r_live - sos_pkg::LIVE_W'(1));

    always_comb begin
        n_fill   = r_fill;
        n_order  = r_order;
        n_live   = r_live;
        n_in_use = r_in_use;
        plan     = '0;
        plan.status = sos_pkg::STAT_OK;
        pos      = last_pos;
        slot     = r_order[last_pos];
        fill     = r_fill[slot];
        need_new = 1'b0;
        case (i_beat.cmd)
            sos_pkg::CMD_PUSH: begin
                need_new = (r_live == '0) || (fill >= eff_cap);
                if (need_new) begin
                    if ((32'(r_live) >= 32'(sos_pkg::MAX_STACKS)) || !free_found) begin
                        plan.status = sos_pkg::STAT_FULL;
                    end else begin
                        slot = free_slot;
                        fill = '0;
                        n_in_use[free_slot] = 1'b1;
                        n_order[sos_pkg::SLOT_W'(r_live)] = free_slot;
                        n_live = r_live + sos_pkg::LIVE_W'(1);
                    end
                end
                if (plan.status == sos_pkg::STAT_OK) begin
                    plan.wr_en   = 1'b1;
                    plan.addr    = sos_pkg::ADDR_W'(slot) *
                                   sos_pkg::ADDR_W'(sos_pkg::MAX_CAPACITY) +
                                   sos_pkg::ADDR_W'(fill);
                    n_fill[slot] = fill + sos_pkg::FILL_W'(1);
                end
            end
            sos_pkg::CMD_POP, sos_pkg::CMD_POP_AT: begin
                if (r_live == '0) begin
                    plan.status = sos_pkg::STAT_EMPTY;
                end else if ((i_beat.cmd == sos_pkg::CMD_POP_AT) &&
                             (32'(i_beat.stack_index) >= 32'(r_live))) begin
                    plan.status = sos_pkg::STAT_RANGE;
                end else begin
                    if (i_beat.cmd == sos_pkg::CMD_POP_AT) begin
                        pos = sos_pkg::SLOT_W'(i_beat.stack_index);
                    end
                    slot = r_order[pos];
                    fill = r_fill[slot] - sos_pkg::FILL_W'(1);
                    plan.rd_en   = 1'b1;
                    plan.addr    = sos_pkg::ADDR_W'(slot) *
                                   sos_pkg::ADDR_W'(sos_pkg::MAX_CAPACITY) +
                                   sos_pkg::ADDR_W'(fill);
                    n_fill[slot] = fill;
                    if (fill == '0) begin
                        n_in_use[slot] = 1'b0;
                        for (int i = 0; i < sos_pkg::MAX_STACKS - 1; i++) begin
                            if (sos_pkg::SLOT_W'(i) >= pos) begin
                                n_order[i] = r_order[i + 1];
                            end
                        end
                        n_live = r_live - sos_pkg::LIVE_W'(1);
                    end
                end
            end
            default: begin
                plan.status = sos_pkg::STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sos_pkg::MAX_STACKS; i++) begin
                r_fill[i] <= '0;
            end
            r_live   <= '0;
            r_in_use <= '0;
        end else if (i_go) begin
            r_fill   <= n_fill;
            r_live   <= n_live;
            r_in_use <= n_in_use;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_order <= n_order;
        end
    end

    assign o_plan = plan;

endmodule

### src/set_of_stacks.sv
// Top level of set_of_stacks: handshake control, value RAM, directory and register port.
//
// A stack split into an ordered list of sub-stacks of sub_capacity values each, with
// push, pop and pop-at commands; every command returns one result beat with the popped
// value and a status. A push, an error or an unused command writes its result into
// the output register. A successful pop or pop-at first passes through the registered
// read of the value RAM; no new command is taken while that read is in flight. The
// directory's counts and slot flags are cleared at reset, so no clearing pass is needed.
// A finished result waits in an output register; no new command is taken while it is
// stalled. sub_capacity sits at address 0; 0 acts as 1 and values above 16 act as 16.
module set_of_stacks (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sos_pkg::t_in_beat     i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sos_pkg::t_out_beat    o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    sos_pkg::t_state             r_state;
    sos_pkg::t_state             n_state;
    logic                        r_out_valid;
    logic                        n_out_valid;
    sos_pkg::t_out_beat          r_out;
    sos_pkg::t_out_beat          n_out;
    logic [sos_pkg::CAP_W-1:0]   r_sub_capacity;
    sos_pkg::t_plan              plan;
    logic                        accept;
    logic                        can_take;
    logic [sos_pkg::DATA_W-1:0]  ram_rdata;

    assign can_take   = (r_state == sos_pkg::S_IDLE) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !can_take;
    assign accept     = i_in_valid && can_take;

    sos_dir u_dir (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (accept),
        .i_beat         (i_in),
        .i_sub_capacity (r_sub_capacity),
        .o_plan         (plan)
    );

    sos_ram #(
        .WIDTH (sos_pkg::DATA_W),
        .DEPTH (sos_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (accept && (plan.wr_en || plan.rd_en)),
        .i_we    (plan.wr_en),
        .i_addr  (plan.addr),
        .i_wdata (i_in.push_value),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            sos_pkg::S_IDLE: begin
                if (accept && plan.rd_en) begin
                    n_state = sos_pkg::S_READ;
                end
            end
            sos_pkg::S_READ: begin
                n_state = sos_pkg::S_IDLE;
            end
            default: begin
                n_state = sos_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        case (r_state)
            sos_pkg::S_IDLE: begin
                if (accept && !plan.rd_en) begin
                    n_out_valid     = 1'b1;
                    n_out.pop_value = '0;
                    n_out.status    = plan.status;
                end
            end
            sos_pkg::S_READ: begin
                n_out_valid     = 1'b1;
                n_out.pop_value = ram_rdata;
                n_out.status    = sos_pkg::STAT_OK;
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sos_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_capacity <= sos_pkg::SUB_CAPACITY_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == sos_pkg::REG_SUB_CAPACITY)) begin
            r_sub_capacity <= pwdata[sos_pkg::CAP_W-1:0];
        end
    end

    assign prdata      = (paddr[2] == sos_pkg::REG_SUB_CAPACITY) ?
                         32'(r_sub_capacity) : '0;
    assign pready      = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_read_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sos_pkg::S_READ |=> r_state == sos_pkg::S_IDLE)
        else $error("RAM read state lasted more than one cycle");

    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sos_pkg::S_READ |-> !r_out_valid)
        else $error("Output register busy while a pop read is in flight");

    a_pop_goes_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && plan.rd_en |=> r_state == sos_pkg::S_READ && !o_out_valid)
        else $error("Successful pop did not wait for the RAM read");

    a_no_take_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sos_pkg::S_READ |-> !accept)
        else $error("Command taken while a pop read is in flight");

endmodule
